// File: src/mmic_pkg.sv
// ----------------------------------------------------------------------------
// mmic_pkg
// Shared types and constants for the matrix multiply and identity check
// block: field widths, controller states and the control/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package mmic_pkg;

  // Field widths
  localparam int ELEM_W = 16;   // input matrix element
  localparam int PROD_W = 32;   // one element product
  localparam int ACC_W  = 35;   // product entry accumulator

  // Controller states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_READ,
    ST_MUL,
    ST_ACC,
    ST_OUT
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load_wr;   // store the element of an accepted transaction
    logic clr_acc;   // clear the accumulator before the product phase
    logic mul_en;    // register the product of the two read elements
    logic acc_en;    // add the product, step the inner index
    logic out_adv;   // result taken: step to the next product entry
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic load_last; // element being loaded is the last one of B
    logic k_last;    // inner index is at its final term
    logic cell_last; // current entry is the final entry of the product
  } status_t;

endpackage

`default_nettype wire

// File: src/mmic_ram.sv
// ----------------------------------------------------------------------------
// mmic_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mmic_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/mmic_dp.sv
// ----------------------------------------------------------------------------
// mmic_dp
// Datapath: element stores for A and B, load and index counters, one shared
// multiply-accumulate unit and the running identity check.
// ----------------------------------------------------------------------------
`default_nettype none

module mmic_dp #(
  parameter int DIM = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire mmic_pkg::cmd_t                cmd,
  input  wire logic signed [mmic_pkg::ELEM_W-1:0] element,
  output mmic_pkg::status_t                  status,
  output logic signed [mmic_pkg::ACC_W-1:0]  product_entry,
  output logic                               last_entry,
  output logic                               is_inverse
);

  import mmic_pkg::*;

  localparam int CELLS = DIM * DIM;
  localparam int CW    = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DW    = (DIM > 1) ? $clog2(DIM) : 1;

  logic              load_b;
  logic [CW-1:0]     load_idx;
  logic [DW-1:0]     r, c, k;
  logic [CW-1:0]     a_raddr, b_raddr;
  logic [ELEM_W-1:0] a_q, b_q;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;
  logic              identity_so_far;
  logic              load_wrap, k_last, c_last, r_last, cell_last, match;

  // Status
  assign load_wrap = (load_idx == CW'(CELLS - 1));
  assign k_last    = (k == DW'(DIM - 1));
  assign c_last    = (c == DW'(DIM - 1));
  assign r_last    = (r == DW'(DIM - 1));
  assign cell_last = r_last & c_last;

  assign status.load_last = load_b & load_wrap;
  assign status.k_last    = k_last;
  assign status.cell_last = cell_last;

  // Load position: cell index plus a flag for the B half
  always_ff @(posedge clk) begin
    if (rst) begin
      load_idx <= '0;
      load_b   <= 1'b0;
    end else if (cmd.load_wr) begin
      if (load_wrap) begin
        load_idx <= '0;
        load_b   <= ~load_b;
      end else begin
        load_idx <= load_idx + CW'(1);
      end
    end
  end

  // Row-major read addresses: A[r][k] and B[k][c]
  assign a_raddr = CW'(r * DIM + k);
  assign b_raddr = CW'(k * DIM + c);

  mmic_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_a_ram (
    .clk   (clk),
    .we    (cmd.load_wr & ~load_b),
    .waddr (load_idx),
    .wdata (element),
    .raddr (a_raddr),
    .rdata (a_q)
  );

  mmic_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_b_ram (
    .clk   (clk),
    .we    (cmd.load_wr & load_b),
    .waddr (load_idx),
    .wdata (element),
    .raddr (b_raddr),
    .rdata (b_q)
  );

  // Multiply stage
  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= $signed(a_q) * $signed(b_q);
    end
  end

  // Accumulator, doubles as the output register while a result waits
  always_ff @(posedge clk) begin
    if (cmd.clr_acc || cmd.out_adv) begin
      acc <= '0;
    end else if (cmd.acc_en) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Inner index
  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if (cmd.acc_en) begin
      k <= k_last ? '0 : k + DW'(1);
    end
  end

  // Entry position, row-major
  always_ff @(posedge clk) begin
    if (rst) begin
      r <= '0;
      c <= '0;
    end else if (cmd.out_adv) begin
      if (c_last) begin
        c <= '0;
        r <= r_last ? '0 : r + DW'(1);
      end else begin
        c <= c + DW'(1);
      end
    end
  end

  // Identity check across all entries
  assign match = (acc == ((r == c) ? ACC_W'(1) : '0));

  always_ff @(posedge clk) begin
    if (rst) begin
      identity_so_far <= 1'b1;
    end else if (cmd.out_adv) begin
      identity_so_far <= cell_last ? 1'b1 : (identity_so_far & match);
    end
  end

  assign product_entry = acc;
  assign last_entry    = cell_last;
  assign is_inverse    = cell_last & identity_so_far & match;

endmodule

`default_nettype wire

// File: src/mmic_ctrl.sv
// ----------------------------------------------------------------------------
// mmic_ctrl
// Controller: sequences loading, the read/multiply/accumulate steps of each
// product entry and the hand-off of each result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mmic_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              out_stall,
  input  wire mmic_pkg::status_t status,
  output mmic_pkg::cmd_t         cmd,
  output logic                   in_stall,
  output logic                   out_valid
);

  import mmic_pkg::*;

  state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_LOAD: begin
        if (in_valid && status.load_last) state_next = ST_READ;
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        state_next = status.k_last ? ST_OUT : ST_READ;
      end
      ST_OUT: begin
        if (!out_stall) state_next = status.cell_last ? ST_LOAD : ST_READ;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Outputs
  always_comb begin
    cmd       = '0;
    in_stall  = 1'b1;
    out_valid = 1'b0;
    unique case (state)
      ST_LOAD: begin
        in_stall    = 1'b0;
        cmd.load_wr = in_valid;
        cmd.clr_acc = in_valid & status.load_last;
      end
      ST_READ: ;
      ST_MUL:  cmd.mul_en = 1'b1;
      ST_ACC:  cmd.acc_en = 1'b1;
      ST_OUT: begin
        out_valid   = 1'b1;
        cmd.out_adv = ~out_stall;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: src/matrix_multiply_identity_check.sv
// ----------------------------------------------------------------------------
// matrix_multiply_identity_check
// Loads two DIM x DIM signed matrices and streams out their exact product,
// flagging on the last entry whether the product is the identity.
// ----------------------------------------------------------------------------
// Elements arrive one per transaction, row-major, all of A and then all of B;
// loading takes one element per cycle while in_valid is high. Once the last
// element of B is in, input stalls while the product is formed by a single
// shared multiply-accumulate unit behind registered RAM reads: each term
// passes through a read, a multiply and an accumulate step, and each entry
// then waits in a hand-off step while the output is stalled. Entries leave
// row-major; last_entry marks the final one, and is_inverse on it is 1 when
// A*B equals the identity. The block then takes the next pair.
`default_nettype none

module matrix_multiply_identity_check #(
  parameter int DIM = 2
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic signed [mmic_pkg::ELEM_W-1:0]  element,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic signed [mmic_pkg::ACC_W-1:0]        product_entry,
  output logic                                     last_entry,
  output logic                                     is_inverse
);

  import mmic_pkg::*;

  cmd_t    cmd;
  status_t status;

  mmic_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid)
  );

  mmic_dp #(.DIM(DIM)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .element       (element),
    .status        (status),
    .product_entry (product_entry),
    .last_entry    (last_entry),
    .is_inverse    (is_inverse)
  );

  // Loading and result hand-off never overlap
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall))
    else $error("result offered while loading");

  // The identity flag only rides on the final entry
  a_flag_on_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_inverse) |-> last_entry)
    else $error("is_inverse set on a non-final entry");

  // After the final entry is taken, loading resumes
  a_back_to_load: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_entry) |=> !in_stall)
    else $error("not ready for the next matrix pair");

  // Accepting the last element of B starts the product phase
  a_start_product: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && u_dp.status.load_last) |=> in_stall)
    else $error("input not stalled during product phase");

endmodule

`default_nettype wire

// File: dv/matrix_multiply_identity_check_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_identity_check_tb
// Streams pairs of signed matrices into the block under random input gaps and
// output stalls. A scoreboard forms each exact product and checks every entry
// (value, last mark and identity flag) in arrival order.
// ----------------------------------------------------------------------------

module matrix_multiply_identity_check_tb;
  import mmic_pkg::*;

  localparam int DIM            = 2;
  localparam int CELLS          = DIM * DIM;
  localparam int PAIR_CYCLES    = 3 * DIM * DIM * DIM + DIM * DIM;
  localparam int DIRECTED_PAIRS = 3;
  localparam int RANDOM_PAIRS   = (330 - DIRECTED_PAIRS * 2 * CELLS) / (2 * CELLS);
  localparam int CYCLE_LIMIT    =
    20 * (DIRECTED_PAIRS + RANDOM_PAIRS) * (3 * CELLS * 17 + PAIR_CYCLES) + 1000;

  typedef struct packed {
    logic signed [ACC_W-1:0] product;
    logic                    last;
    logic                    inverse;
  } product_entry_t;

  // Scoreboard: collects accepted elements and queues the product entries
  class matrix_product_tracker #(int DIM = 2);
    localparam int CELLS = DIM * DIM;

    logic signed [ELEM_W-1:0] a_cells[CELLS];
    logic signed [ELEM_W-1:0] b_cells[CELLS];
    int unsigned              loaded;
    product_entry_t           pending_entries[$];

    function new();
      loaded = 0;
    endfunction

    // Note one accepted element; the last element of B yields the product
    function void take_element(logic signed [ELEM_W-1:0] value);
      longint         acc;
      bit             all_identity;
      product_entry_t entry;
      if (loaded < CELLS) begin
        a_cells[loaded] = value;
      end else begin
        b_cells[loaded - CELLS] = value;
      end
      loaded++;
      if (loaded < 2 * CELLS) return;
      loaded = 0;
      all_identity = 1'b1;
      for (int r = 0; r < DIM; r++) begin
        for (int c = 0; c < DIM; c++) begin
          acc = 0;
          for (int k = 0; k < DIM; k++) begin
            acc += longint'(a_cells[r * DIM + k]) * longint'(b_cells[k * DIM + c]);
          end
          if (acc != ((r == c) ? 1 : 0)) all_identity = 1'b0;
          entry.product = acc[ACC_W-1:0];
          entry.last    = (r == DIM - 1) && (c == DIM - 1);
          entry.inverse = entry.last ? all_identity : 1'b0;
          pending_entries.push_back(entry);
        end
      end
    endfunction

    // Compare one accepted entry with the oldest pending one; "" means a match
    function string match_entry(logic signed [ACC_W-1:0] product,
                                logic last, logic inverse);
      product_entry_t want;
      string          msg;
      if (pending_entries.size() == 0) begin
        return $sformatf("product entry %0d with none pending", product);
      end
      want = pending_entries.pop_front();
      msg  = "";
      if (product !== want.product) begin
        msg = {msg, $sformatf(" product_entry got %0d want %0d", product, want.product)};
      end
      if (last !== want.last) begin
        msg = {msg, $sformatf(" last_entry got %b want %b", last, want.last)};
      end
      if (inverse !== want.inverse) begin
        msg = {msg, $sformatf(" is_inverse got %b want %b", inverse, want.inverse)};
      end
      return msg;
    endfunction
  endclass

  typedef matrix_product_tracker #(DIM) tracker_t;

  typedef enum int {
    PAIR_FULL,
    PAIR_SMALL,
    PAIR_EXTREME,
    PAIR_INVERSE,
    PAIR_NEAR_MISS
  } pair_kind_t;

  logic                     clk = 1'b0;
  logic                     rst;
  logic                     in_valid;
  logic                     in_stall;
  logic signed [ELEM_W-1:0] element;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [ACC_W-1:0]  product_entry;
  logic                     last_entry;
  logic                     is_inverse;

  logic signed [ELEM_W-1:0] mat_a[CELLS];
  logic signed [ELEM_W-1:0] mat_b[CELLS];
  bit                       calm_send;
  bit                       calm_recv;
  int                       mismatch_count;
  int                       cycle_count;

  tracker_t tracker = new();

  always #5 clk = ~clk;

  matrix_multiply_identity_check #(.DIM(DIM)) dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .element      (element),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .product_entry(product_entry),
    .last_entry   (last_entry),
    .is_inverse   (is_inverse)
  );

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH @%0t:%s", $time, what);
  endtask

  // One input transaction: optional gap, then hold until accepted
  task automatic send_element(input logic signed [ELEM_W-1:0] value);
    int gap;
    gap = calm_send ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    element  <= value;
    do @(posedge clk); while (in_stall);
    tracker.take_element(value);
    @(negedge clk);
  endtask

  task automatic send_pair();
    foreach (mat_a[i]) send_element(mat_a[i]);
    foreach (mat_b[i]) send_element(mat_b[i]);
  endtask

  // Hold off the sender until every queued product entry has come back
  task automatic wait_for_products();
    in_valid <= 1'b0;
    @(negedge clk);
    while (tracker.pending_entries.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_extreme();
    case ($urandom_range(0, 6))
      0:       return -16'sd32768;
      1:       return -16'sd32767;
      2:       return -16'sd1;
      3:       return 16'sd0;
      4:       return 16'sd1;
      5:       return 16'sd32766;
      default: return 16'sd32767;
    endcase
  endfunction

  function automatic void fill_pair(pair_kind_t kind);
    int                       r;
    int                       c;
    int                       spot;
    logic signed [ELEM_W-1:0] shear;
    logic signed [ELEM_W-1:0] sign;
    case (kind)
      PAIR_FULL: begin
        foreach (mat_a[i]) begin
          mat_a[i] = ELEM_W'($urandom);
          mat_b[i] = ELEM_W'($urandom);
        end
      end
      PAIR_SMALL: begin
        foreach (mat_a[i]) begin
          mat_a[i] = ELEM_W'(int'($urandom_range(0, 6)) - 3);
          mat_b[i] = ELEM_W'(int'($urandom_range(0, 6)) - 3);
        end
      end
      PAIR_EXTREME: begin
        foreach (mat_a[i]) begin
          mat_a[i] = pick_extreme();
          mat_b[i] = pick_extreme();
        end
      end
      default: begin
        // B built as the exact inverse of A: a shear or a sign diagonal
        foreach (mat_a[i]) begin
          mat_a[i] = (i % (DIM + 1) == 0) ? 16'sd1 : 16'sd0;
          mat_b[i] = mat_a[i];
        end
        if (DIM > 1 && $urandom_range(0, 1) == 1) begin
          r     = $urandom_range(0, DIM - 1);
          c     = (r + 1 + $urandom_range(0, DIM - 2)) % DIM;
          shear = ELEM_W'($urandom);
          mat_a[r * DIM + c] = shear;
          mat_b[r * DIM + c] = -shear;
        end else begin
          for (int d = 0; d < DIM; d++) begin
            sign = ($urandom_range(0, 1) == 1) ? -16'sd1 : 16'sd1;
            mat_a[d * (DIM + 1)] = sign;
            mat_b[d * (DIM + 1)] = sign;
          end
        end
        // near miss: one flipped bit somewhere in B
        if (kind == PAIR_NEAR_MISS) begin
          spot = $urandom_range(0, CELLS - 1);
          mat_b[spot] = mat_b[spot] ^ ELEM_W'(1 << $urandom_range(0, ELEM_W - 1));
        end
      end
    endcase
  endfunction

  // Stimulus and end of run
  initial begin : stimulus
    pair_kind_t kind;
    int         pick;
    rst            = 1'b1;
    in_valid       = 1'b0;
    element        = '0;
    out_stall      = 1'b0;
    calm_send      = 1'b0;
    calm_recv      = 1'b0;
    mismatch_count = 0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // identity times identity
    foreach (mat_a[i]) begin
      mat_a[i] = (i % (DIM + 1) == 0) ? 16'sd1 : 16'sd0;
      mat_b[i] = mat_a[i];
    end
    send_pair();
    // largest shear and its inverse
    mat_a[DIM - 1] = 16'sd32767;
    mat_b[DIM - 1] = -16'sd32767;
    send_pair();
    // most negative elements: widest positive and negative entries
    foreach (mat_a[i]) begin
      mat_a[i] = -16'sd32768;
      mat_b[i] = (i % DIM == 0) ? -16'sd32768 : 16'sd32767;
    end
    send_pair();
    wait_for_products();

    // random pairs, roughly half of them inverse or near-inverse
    for (int p = 0; p < RANDOM_PAIRS; p++) begin
      calm_send = ($urandom_range(0, 3) == 0);
      calm_recv = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 5)       kind = PAIR_FULL;
      else if (pick < 8)  kind = PAIR_SMALL;
      else if (pick < 10) kind = PAIR_EXTREME;
      else if (pick < 16) kind = PAIR_INVERSE;
      else                kind = PAIR_NEAR_MISS;
      fill_pair(kind);
      send_pair();
      if (p == 4 || $urandom_range(0, 9) == 0) wait_for_products();
    end

    wait_for_products();
    repeat (PAIR_CYCLES + 16) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("matrix_multiply_identity_check regression: pass");
    end else begin
      $display("matrix_multiply_identity_check regression: fail");
    end
    $finish;
  end

  // Result side: random stall before each transaction, check on acceptance
  initial begin : result_sink
    int    hold;
    string verdict;
    @(negedge rst);
    forever begin
      hold = calm_recv ? 0 : $urandom_range(0, 15);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (out_valid !== 1'b1);
      verdict = tracker.match_entry(product_entry, last_entry, is_inverse);
      if (verdict != "") report_mismatch(verdict);
      @(negedge clk);
    end
  end

  // Watchdog
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("matrix_multiply_identity_check regression: fail");
    $finish;
  end

endmodule
